FILE: src/mcma_pkg.sv
// ----------------------------------------------------------------------------
// mcma_pkg
// Shared constants for the multichannel moving average block: fixed port
// widths, register reset value and queue depth.
// ----------------------------------------------------------------------------
package mcma_pkg;

    // fixed field widths of the ports
    localparam int CHANNEL_BITS   = 4;
    localparam int SAMPLE_IN_BITS = 12;
    localparam int AVERAGE_BITS   = 12;

    // channels_in_use register
    localparam int              CIU_BITS  = 5;
    localparam logic [CIU_BITS-1:0] CIU_RESET = 5'd10;

    // words held between the classifier and the update pipeline
    localparam int QUEUE_DEPTH = 4;

endpackage

FILE: src/mcma_front.sv
// ----------------------------------------------------------------------------
// mcma_front
// Input side: holds the channel count register and the shared window slot,
// classifies each word as good or bad, forms the store address and pushes
// the word into the queue.
// ----------------------------------------------------------------------------
module mcma_front #(
    parameter int MAX_CHANNELS = 16,
    parameter int WINDOW       = 128,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // sample channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [mcma_pkg::CHANNEL_BITS-1:0]       s_channel,
    input  logic [mcma_pkg::SAMPLE_IN_BITS-1:0]     s_sample,
    // configuration channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mcma_pkg::CIU_BITS-1:0]           cfg_data,
    // store clearing in progress
    input  logic                                    clearing,
    // queue push side
    output logic                                    q_valid,
    input  logic                                    q_ready,
    output logic [$clog2(MAX_CHANNELS*WINDOW)-1:0]  q_addr,
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] q_idx,
    output logic [mcma_pkg::CHANNEL_BITS-1:0]       q_channel,
    output logic [SAMPLE_BITS-1:0]                  q_sample,
    output logic                                    q_bad
);

    localparam int SLW   = $clog2(WINDOW);
    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ADDRW = $clog2(MAX_CHANNELS*WINDOW);
    localparam int MAXW  = $clog2(MAX_CHANNELS + 1);
    localparam int ACTW  = (MAXW > mcma_pkg::CIU_BITS) ? MAXW : mcma_pkg::CIU_BITS;
    localparam logic [ACTW-1:0]  MAX_CH    = ACTW'(MAX_CHANNELS);
    localparam logic [SLW-1:0]   SLOT_LAST = SLW'(WINDOW - 1);

    logic [mcma_pkg::CIU_BITS-1:0] ciu_reg;
    logic [SLW-1:0]                slot_reg;
    logic [SLW-1:0]                slot_next;
    logic [ACTW-1:0]               ciu_ext;
    logic [ACTW-1:0]               active;
    logic [ACTW-1:0]               ch_ext;
    logic                          bad;
    logic                          last;
    logic                          push;

    // effective channel count saturates at the channel capacity
    assign ciu_ext = ACTW'(ciu_reg);
    assign active  = (ciu_ext > MAX_CH) ? MAX_CH : ciu_ext;
    assign ch_ext  = ACTW'(s_channel);
    assign bad     = (ch_ext >= active);
    assign last    = (ch_ext == active - 1'b1);

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_ready   = q_ready & ~clearing;
    assign q_valid   = s_valid & ~clearing;
    assign push      = s_valid & s_ready;

    // queue word
    assign q_bad     = bad;
    assign q_channel = s_channel;
    assign q_sample  = SAMPLE_BITS'(s_sample);
    assign q_idx     = CHW'(s_channel);
    assign q_addr    = bad ? '0 : ADDRW'(ADDRW'(q_idx) * ADDRW'(WINDOW) + ADDRW'(slot_reg));

    // slot advances after the last channel in the scan
    assign slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ciu_reg  <= mcma_pkg::CIU_RESET;
            slot_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                ciu_reg <= cfg_data;
            end
            if (push && !bad && last) begin
                slot_reg <= slot_next;
            end
        end
    end

    // a rejected word never moves the slot
    a_bad_keeps_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        push && bad |=> $stable(slot_reg))
        else $error("slot index moved on a rejected word");

endmodule

FILE: src/mcma_fifo.sv
// ----------------------------------------------------------------------------
// mcma_fifo
// Short first-in first-out queue with valid/ready on both sides; decouples
// the classifier from the update pipeline.
// ----------------------------------------------------------------------------
module mcma_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int DEPTH = mcma_pkg::QUEUE_DEPTH;
    localparam int PTRW  = $clog2(DEPTH);
    localparam logic [PTRW-1:0] PTR_LAST = PTRW'(DEPTH - 1);
    localparam logic [PTRW:0]   CNT_FULL = (PTRW+1)'(DEPTH);

    logic [WIDTH-1:0] buf_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [PTRW:0]    count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_data  = buf_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/mcma_back.sv
// ----------------------------------------------------------------------------
// mcma_back
// Update pipeline: reads the old sample and the channel sum, forwards the
// last write, writes back the new sample and sum, divides the sum by the
// window length with a reciprocal multiply and registers the result word.
// Also runs the clearing pass over both stores after reset.
// ----------------------------------------------------------------------------
module mcma_back #(
    parameter int MAX_CHANNELS = 16,
    parameter int WINDOW       = 128,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // queue pop side
    input  logic                                    q_valid,
    output logic                                    q_ready,
    input  logic [$clog2(MAX_CHANNELS*WINDOW)-1:0]  q_addr,
    input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] q_idx,
    input  logic [mcma_pkg::CHANNEL_BITS-1:0]       q_channel,
    input  logic [SAMPLE_BITS-1:0]                  q_sample,
    input  logic                                    q_bad,
    // store clearing in progress
    output logic                                    clearing,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [mcma_pkg::CHANNEL_BITS-1:0]       m_out_channel,
    output logic [mcma_pkg::AVERAGE_BITS-1:0]       m_average,
    output logic                                    m_bad_channel
);

    localparam int SW    = SAMPLE_BITS;
    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DEPTH = MAX_CHANNELS * WINDOW;
    localparam int ADDRW = $clog2(DEPTH);
    localparam int SUMW  = SW + $clog2(WINDOW);
    // ceil(2^SHIFT / WINDOW) gives the exact floor quotient for any sum
    localparam int SHIFT = SUMW + $clog2(WINDOW);
    localparam int MW    = SUMW + 1;
    localparam int PW    = SUMW + MW;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW);
    localparam logic [MW-1:0]    RECIP    = RECIP_WIDE[MW-1:0];
    localparam logic [ADDRW-1:0] CLR_LAST = ADDRW'(DEPTH - 1);
    localparam logic [ADDRW-1:0] SUM_ENDS = ADDRW'(MAX_CHANNELS);

    // stores
    logic [SW-1:0]   store_mem [DEPTH];
    logic [SUMW-1:0] sum_mem   [MAX_CHANNELS];

    logic                               clr_reg;
    logic [ADDRW-1:0]                   clr_cnt_reg;
    logic                               en;
    logic                               pop;
    logic                               wr_en;

    // stage 1: read data back from the stores
    logic                               p1_valid_reg;
    logic [ADDRW-1:0]                   p1_addr_reg;
    logic [CHW-1:0]                     p1_idx_reg;
    logic [mcma_pkg::CHANNEL_BITS-1:0]  p1_ch_reg;
    logic [SW-1:0]                      p1_sample_reg;
    logic                               p1_bad_reg;
    logic [SW-1:0]                      old_rd_reg;
    logic [SUMW-1:0]                    sum_rd_reg;

    // last write, for forwarding
    logic                               wb_valid_reg;
    logic [ADDRW-1:0]                   wb_addr_reg;
    logic [CHW-1:0]                     wb_idx_reg;
    logic [SW-1:0]                      wb_sample_reg;
    logic [SUMW-1:0]                    wb_sum_reg;

    logic [SW-1:0]                      old_fwd;
    logic [SUMW-1:0]                    sum_fwd;
    logic [SUMW-1:0]                    sum_next;

    // stage 2: new sum
    logic                               p2_valid_reg;
    logic [mcma_pkg::CHANNEL_BITS-1:0]  p2_ch_reg;
    logic                               p2_bad_reg;
    logic [SUMW-1:0]                    p2_sum_reg;

    // stage 3: reciprocal product
    logic                               p3_valid_reg;
    logic [mcma_pkg::CHANNEL_BITS-1:0]  p3_ch_reg;
    logic                               p3_bad_reg;
    logic [PW-1:0]                      p3_prod_reg;
    logic [PW-1:0]                      quot;

    // output register
    logic                               m_valid_reg;
    logic [mcma_pkg::CHANNEL_BITS-1:0]  m_out_channel_reg;
    logic [mcma_pkg::AVERAGE_BITS-1:0]  m_average_reg;
    logic                               m_bad_reg;

    // whole pipeline moves unless the output word is stuck
    assign en       = ~m_valid_reg | m_ready;
    assign q_ready  = en;
    assign pop      = q_valid & en;
    assign wr_en    = p1_valid_reg & ~p1_bad_reg & en;
    assign clearing = clr_reg;

    // clearing pass, one store entry per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (clr_reg) begin
            if (clr_cnt_reg == CLR_LAST) begin
                clr_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // store ports: one write, one registered read each
    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            store_mem[clr_cnt_reg] <= '0;
            if (clr_cnt_reg < SUM_ENDS) begin
                sum_mem[clr_cnt_reg[CHW-1:0]] <= '0;
            end
        end else if (wr_en) begin
            store_mem[p1_addr_reg] <= p1_sample_reg;
            sum_mem[p1_idx_reg]    <= sum_next;
        end
        if (pop) begin
            old_rd_reg <= store_mem[q_addr];
            sum_rd_reg <= sum_mem[q_idx];
        end
    end

    // forward the write made at the read edge
    assign old_fwd  = (wb_valid_reg && wb_addr_reg == p1_addr_reg) ? wb_sample_reg : old_rd_reg;
    assign sum_fwd  = (wb_valid_reg && wb_idx_reg == p1_idx_reg) ? wb_sum_reg : sum_rd_reg;
    assign sum_next = sum_fwd - SUMW'(old_fwd) + SUMW'(p1_sample_reg);

    assign quot = p3_prod_reg >> SHIFT;

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            wb_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                p1_valid_reg <= pop;
                p2_valid_reg <= p1_valid_reg;
                p3_valid_reg <= p2_valid_reg;
                m_valid_reg  <= p3_valid_reg;
            end
            if (wr_en) begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            p1_addr_reg   <= q_addr;
            p1_idx_reg    <= q_idx;
            p1_ch_reg     <= q_channel;
            p1_sample_reg <= q_sample;
            p1_bad_reg    <= q_bad;
        end
        if (wr_en) begin
            wb_addr_reg   <= p1_addr_reg;
            wb_idx_reg    <= p1_idx_reg;
            wb_sample_reg <= p1_sample_reg;
            wb_sum_reg    <= sum_next;
        end
        if (en) begin
            p2_ch_reg         <= p1_ch_reg;
            p2_bad_reg        <= p1_bad_reg;
            p2_sum_reg        <= p1_bad_reg ? '0 : sum_next;
            p3_ch_reg         <= p2_ch_reg;
            p3_bad_reg        <= p2_bad_reg;
            p3_prod_reg       <= PW'(p2_sum_reg) * PW'(RECIP);
            m_out_channel_reg <= p3_ch_reg;
            m_bad_reg         <= p3_bad_reg;
            m_average_reg     <= quot[mcma_pkg::AVERAGE_BITS-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_out_channel_reg;
    assign m_average     = m_average_reg;
    assign m_bad_channel = m_bad_reg;

    // no word is in flight while the stores are being cleared
    a_no_work_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_reg |-> !p1_valid_reg && !pop)
        else $error("word in pipeline during clearing pass");

    // clearing stops right after the last entry
    a_clear_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_reg && clr_cnt_reg == CLR_LAST |=> !clr_reg)
        else $error("clearing pass did not stop");

    // a rejected word reports a zero average
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_bad_reg |-> m_average_reg == '0)
        else $error("rejected word with nonzero average");

endmodule

FILE: src/multichannel_moving_average.sv
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Per-channel moving average over the last WINDOW converter samples with a
// shared window slot and running sums.
// ----------------------------------------------------------------------------
// Sustained rate is one word per clock while m_ready stays high: the sample
// store and the sum store each do one read and one write per cycle, and the
// previous write is forwarded so back-to-back words on the same channel need
// no bubble. A word passes through the queue, the store read, the sum, the
// reciprocal multiply and the output register in that order; classification
// is combinational. After reset both stores are zeroed by a clearing pass
// over all MAX_CHANNELS*WINDOW entries (2048 at the defaults), during which
// s_ready stays low; configuration writes are taken throughout. Channels at
// or above channels_in_use (capped at MAX_CHANNELS) return bad_channel with
// a zero average and change nothing.
// ----------------------------------------------------------------------------
module multichannel_moving_average #(
    parameter int MAX_CHANNELS = 16,
    parameter int WINDOW       = 128,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mcma_pkg::CHANNEL_BITS-1:0]   s_channel,
    input  logic [mcma_pkg::SAMPLE_IN_BITS-1:0] s_sample,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mcma_pkg::CHANNEL_BITS-1:0]   m_out_channel,
    output logic [mcma_pkg::AVERAGE_BITS-1:0]   m_average,
    output logic                                m_bad_channel,
    // channels_in_use write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mcma_pkg::CIU_BITS-1:0]       cfg_data
);

    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ADDRW = $clog2(MAX_CHANNELS*WINDOW);
    localparam int QW    = ADDRW + CHW + mcma_pkg::CHANNEL_BITS + SAMPLE_BITS + 1;

    logic                               clearing;
    logic                               fq_valid;
    logic                               fq_ready;
    logic [ADDRW-1:0]                   fq_addr;
    logic [CHW-1:0]                     fq_idx;
    logic [mcma_pkg::CHANNEL_BITS-1:0]  fq_channel;
    logic [SAMPLE_BITS-1:0]             fq_sample;
    logic                               fq_bad;
    logic [QW-1:0]                      fq_data;

    logic                               bq_valid;
    logic                               bq_ready;
    logic [QW-1:0]                      bq_data;
    logic [ADDRW-1:0]                   bq_addr;
    logic [CHW-1:0]                     bq_idx;
    logic [mcma_pkg::CHANNEL_BITS-1:0]  bq_channel;
    logic [SAMPLE_BITS-1:0]             bq_sample;
    logic                               bq_bad;

    // classifier
    mcma_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .WINDOW       (WINDOW),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_channel (s_channel),
        .s_sample  (s_sample),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .clearing  (clearing),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_addr    (fq_addr),
        .q_idx     (fq_idx),
        .q_channel (fq_channel),
        .q_sample  (fq_sample),
        .q_bad     (fq_bad)
    );

    assign fq_data = {fq_addr, fq_idx, fq_channel, fq_sample, fq_bad};

    // queue between the two sides
    mcma_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    assign {bq_addr, bq_idx, bq_channel, bq_sample, bq_bad} = bq_data;

    // update pipeline
    mcma_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .WINDOW       (WINDOW),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (bq_valid),
        .q_ready       (bq_ready),
        .q_addr        (bq_addr),
        .q_idx         (bq_idx),
        .q_channel     (bq_channel),
        .q_sample      (bq_sample),
        .q_bad         (bq_bad),
        .clearing      (clearing),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_average     (m_average),
        .m_bad_channel (m_bad_channel)
    );

endmodule

FILE: test/mcma_checker.sv
// ----------------------------------------------------------------------------
// mcma_checker
// Watches the sample, result and channels_in_use channels of the moving
// average block. It keeps its own copy of the sample windows, running sums,
// slot index and channel count, and predicts one average word per accepted
// sample word. Each accepted result word is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module mcma_checker #(
    parameter int MAX_CHANNELS = 16,
    parameter int WINDOW       = 128,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [mcma_pkg::CHANNEL_BITS-1:0]   s_channel,
    input  logic [mcma_pkg::SAMPLE_IN_BITS-1:0] s_sample,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [mcma_pkg::CHANNEL_BITS-1:0]   m_out_channel,
    input  logic [mcma_pkg::AVERAGE_BITS-1:0]   m_average,
    input  logic                                m_bad_channel,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [mcma_pkg::CIU_BITS-1:0]       cfg_data,
    output int                                  mismatch_count,
    output int                                  pending_results
);

    typedef struct packed {
        logic [mcma_pkg::CHANNEL_BITS-1:0] channel;
        logic [mcma_pkg::AVERAGE_BITS-1:0] average;
        logic                              bad_channel;
    } average_word_t;

    // predicted averages, oldest first
    average_word_t          expected_averages[$];

    // shadow of the block state
    logic [SAMPLE_BITS-1:0]        window_mem [MAX_CHANNELS*WINDOW];
    logic [31:0]                   sum_mem    [MAX_CHANNELS];
    int                            slot;
    logic [mcma_pkg::CIU_BITS-1:0] channel_count;
    int                            err_count = 0;

    // good sample word: replace the slot entry, adjust the sum, take the mean
    task automatic predict_average(input logic [mcma_pkg::CHANNEL_BITS-1:0] ch,
                                   input logic [mcma_pkg::SAMPLE_IN_BITS-1:0] smp,
                                   output average_word_t w);
        int                     active;
        int                     idx;
        logic [SAMPLE_BITS-1:0] masked;
        logic [SAMPLE_BITS-1:0] old;
        active = (int'(channel_count) > MAX_CHANNELS) ? MAX_CHANNELS
                                                      : int'(channel_count);
        masked = SAMPLE_BITS'(smp);
        w.channel     = ch;
        w.average     = '0;
        w.bad_channel = 1'b1;
        if (int'(ch) < active) begin
            idx              = int'(ch) * WINDOW + slot;
            old              = window_mem[idx];
            window_mem[idx]  = masked;
            sum_mem[ch]      = sum_mem[ch] - 32'(old) + 32'(masked);
            w.average        = mcma_pkg::AVERAGE_BITS'(sum_mem[ch] / WINDOW);
            w.bad_channel    = 1'b0;
            // last scanned channel moves the shared slot on
            if (int'(ch) == active - 1)
                slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, field, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin : monitor
        average_word_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_CHANNELS*WINDOW; i++)
                window_mem[i] = '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
                sum_mem[i] = '0;
            expected_averages.delete();
            slot          = 0;
            channel_count = mcma_pkg::CIU_RESET;
        end else begin
            // writes only happen while idle, so order against samples is moot
            if (cfg_valid && cfg_ready)
                channel_count = cfg_data;

            // result word against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_averages.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result word, expected none, %s",
                             $time, "got:");
                    $display("    channel %0d average %0d bad %0b",
                             m_out_channel, m_average, m_bad_channel);
                end else begin
                    want = expected_averages.pop_front();
                    check_field("out_channel", 32'(want.channel), 32'(m_out_channel));
                    check_field("average", 32'(want.average), 32'(m_average));
                    check_field("bad_channel", 32'(want.bad_channel), 32'(m_bad_channel));
                end
            end

            if (s_valid && s_ready) begin
                predict_average(s_channel, s_sample, want);
                expected_averages.push_back(want);
            end
        end
        pending_results <= expected_averages.size();
        mismatch_count  <= err_count;
    end

endmodule

FILE: test/tb_multichannel_moving_average.sv
// ----------------------------------------------------------------------------
// tb_multichannel_moving_average
// Stimulus and verdict for the multichannel moving average block. A short
// directed part hits the field extremes, rejected channels and the zero,
// one, full and saturated channel counts; random phases then run mostly
// complete channel scans under several channel counts with random gaps and
// back-pressure. The checker beside the block does all predicting.
// ----------------------------------------------------------------------------
module tb_multichannel_moving_average;

    localparam int MAX_CHANNELS       = 16;
    localparam int WINDOW             = 128;
    localparam int SAMPLE_BITS        = 12;
    localparam int NUM_PHASES         = 8;
    localparam int WORDS_PER_PHASE    = 205;
    localparam int RESULT_HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT         = 10000;
    localparam int DRAIN_CYCLES       = 16;

    typedef enum int {MIX_UNIFORM, MIX_HIGH, MIX_LOW} sample_mix_t;

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic [mcma_pkg::CHANNEL_BITS-1:0]   s_channel;
    logic [mcma_pkg::SAMPLE_IN_BITS-1:0] s_sample;
    logic                                m_valid;
    logic                                m_ready;
    logic [mcma_pkg::CHANNEL_BITS-1:0]   m_out_channel;
    logic [mcma_pkg::AVERAGE_BITS-1:0]   m_average;
    logic                                m_bad_channel;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [mcma_pkg::CIU_BITS-1:0]       cfg_data;

    int  mismatch_count;
    int  pending_results;
    int  idle_cycles = 0;
    int  words_sent  = 0;
    int  cfg_writes  = 0;
    int  channel_count = int'(mcma_pkg::CIU_RESET);
    bit  no_gaps       = 1'b0;
    bit  stall_results = 1'b0;
    bit  stall_taken   = 1'b0;

    multichannel_moving_average #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .WINDOW       (WINDOW),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_average     (m_average),
        .m_bad_channel (m_bad_channel),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    mcma_checker #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .WINDOW       (WINDOW),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_channel       (s_channel),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_channel   (m_out_channel),
        .m_average       (m_average),
        .m_bad_channel   (m_bad_channel),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always #5 aclk = ~aclk;

    // mostly short gaps, now and then a long one; none in burst stretches
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [mcma_pkg::SAMPLE_IN_BITS-1:0] next_sample(sample_mix_t mix);
        logic [mcma_pkg::SAMPLE_IN_BITS-1:0] v;
        v = mcma_pkg::SAMPLE_IN_BITS'($urandom_range(0, 4095));
        case (mix)
            MIX_HIGH: if ($urandom_range(0, 9) != 0) v = '1;
            MIX_LOW:  if ($urandom_range(0, 9) != 0) v = '0;
            default:  ;
        endcase
        return v;
    endfunction

    // offer one sample word, valid stays up until taken
    task automatic send_word(input logic [mcma_pkg::CHANNEL_BITS-1:0] ch,
                             input logic [mcma_pkg::SAMPLE_IN_BITS-1:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_channel <= ch;
        s_sample  <= smp;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // stop offering and wait for every predicted average to come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    task automatic write_channel_count(input logic [mcma_pkg::CIU_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        channel_count = int'(v);
        cfg_writes++;
    endtask

    // result side: random ready runs and gaps, plus one forced long hold-off
    initial begin : result_sink
        int run_len;
        int gap_len;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (stall_results && !stall_taken) begin
                m_ready <= 1'b0;
                repeat (RESULT_HOLD_CYCLES) @(posedge aclk);
                stall_taken = 1'b1;
            end
            m_ready <= 1'b1;
            run_len = $urandom_range(1, 24);
            repeat (run_len) @(posedge aclk);
            gap_len = pick_gap();
            if (gap_len > 0) begin
                m_ready <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending_results);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int          phase_ciu     [NUM_PHASES];
        sample_mix_t phase_mix     [NUM_PHASES];
        bit          phase_no_gaps [NUM_PHASES];
        int          p;
        int          c;
        int          good;
        int          active;
        logic [mcma_pkg::CHANNEL_BITS-1:0] ch;

        phase_ciu     = '{1, 2, 16, 3, 17, 5, 10, 31};
        phase_mix     = '{MIX_HIGH, MIX_LOW, MIX_UNIFORM, MIX_HIGH,
                          MIX_UNIFORM, MIX_LOW, MIX_UNIFORM, MIX_HIGH};
        phase_no_gaps = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_channel <= '0;
        s_sample  <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset count of ten: first and last scanned channel, rejected ones
        send_word(4'd0, 12'hFFF);
        send_word(4'd0, 12'h000);     // same channel back to back
        send_word(4'd9, 12'hFFF);     // last channel, slot moves on
        send_word(4'd10, 12'hABC);    // first rejected channel
        send_word(4'd15, 12'hFFF);
        send_word(4'd1, 12'hAAA);
        send_word(4'd2, 12'h555);

        // count of sixteen: all channels in the scan
        drain_results();
        write_channel_count(5'd16);
        send_word(4'd15, 12'hFFF);
        send_word(4'd15, 12'hFFF);
        send_word(4'd0, 12'h001);

        // zero channels: everything rejected, slot frozen
        drain_results();
        write_channel_count(5'd0);
        send_word(4'd0, 12'h07B);
        send_word(4'd15, 12'h000);

        // count above the channel limit saturates
        drain_results();
        write_channel_count(5'd31);
        send_word(4'd15, 12'hFFF);
        send_word(4'd14, 12'h800);

        // single channel: every word on channel 0 advances the slot
        drain_results();
        write_channel_count(5'd1);
        send_word(4'd0, 12'hFFF);
        send_word(4'd0, 12'hFFF);
        send_word(4'd0, 12'hFFF);
        send_word(4'd1, 12'h007);

        // random phases: mostly complete scans, some stray words
        for (p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_channel_count(mcma_pkg::CIU_BITS'(phase_ciu[p]));
            active  = (channel_count > MAX_CHANNELS) ? MAX_CHANNELS : channel_count;
            no_gaps = phase_no_gaps[p];
            // result side holds off while samples keep coming
            if (p == 2)
                stall_results = 1'b1;
            good = 0;
            while (good < WORDS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 85) begin
                    for (c = 0; c < active; c++)
                        send_word(mcma_pkg::CHANNEL_BITS'(c), next_sample(phase_mix[p]));
                    good += active;
                end else begin
                    ch = mcma_pkg::CHANNEL_BITS'($urandom_range(0, 15));
                    send_word(ch, mcma_pkg::SAMPLE_IN_BITS'($urandom_range(0, 4095)));
                    if (int'(ch) < active)
                        good++;
                end
            end
        end
        no_gaps = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d sample words over %0d channel-count writes",
                 words_sent, cfg_writes);
        $display("(zero, one, sixteen, saturated), with result hold-off, %s",
                 "input stalls, burst stretches and window wrap-around.");
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
src/mcma_pkg.sv
src/mcma_front.sv
src/mcma_fifo.sv
src/mcma_back.sv
src/multichannel_moving_average.sv
test/mcma_checker.sv
test/tb_multichannel_moving_average.sv
